[rtl/max_pool_2d_argmax_unit_macros.svh]
// Assertion macros for the max pooling unit.
`ifndef MAX_POOL_2D_ARGMAX_UNIT_MACROS_SVH
`define MAX_POOL_2D_ARGMAX_UNIT_MACROS_SVH

`ifndef SYNTH
`define MP2A_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("max pool unit: implication check failed");
`define MP2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("max pool unit: next-cycle check failed");
`else
`define MP2A_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MP2A_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/mp2a_pkg.sv]
package mp2a_pkg;

    localparam int CFG_BITS      = 11;
    localparam int CFG_ADDR_BITS = 2;
    localparam int WIN_CFG_BITS  = 4;
    localparam int ROW_BITS      = 10;
    localparam int MAX_HEIGHT    = 1024;
    localparam int INDEX_BITS    = 20;
    localparam int WIN_POS_BITS  = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_PLANE_WIDTH   = 2'd0,
        REG_PLANE_HEIGHT  = 2'd1,
        REG_WINDOW_SIZE   = 2'd2,
        REG_WINDOW_STRIDE = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_INDEX = 4'b1000
    } state_t;

endpackage

[rtl/max_pool_2d_argmax_unit.sv]
// channel   direction  accept                 word
// s_        in         s_tvalid && s_tready   pixel_value
// m_        out        m_tvalid && m_tready   max_value, max_index, win_row, win_col; tlast
// cfg_      in         cfg_wr_en              register index, write data
//
// A pixel that completes no window leaves the unit ready for the next. One that completes
// a k x k window is followed by k*k reads through the single read port of the line store,
// a drain step for the last read, and an index step for the multiply into the output register.
// The line store is not cleared by reset; reset and any register write restart the plane.
// A pixel is taken while a result waits in the output register; the index step stalls
// until that result is taken.
`include "max_pool_2d_argmax_unit_macros.svh"

module max_pool_2d_argmax_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 8,
    parameter int DATA_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mp2a_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [mp2a_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_value
    input  logic [((DATA_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // max_value, max_index, win_row, win_col
    output logic [((DATA_BITS+26+7)/8)*8-1:0]   m_tdata,
    output logic                                m_tlast
);

    localparam int OUT_W = ((DATA_BITS + 26 + 7) / 8) * 8;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WB > mp2a_pkg::CFG_BITS) ? WB : mp2a_pkg::CFG_BITS;
    localparam int SW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RB    = mp2a_pkg::ROW_BITS;
    localparam int KB    = mp2a_pkg::WIN_CFG_BITS;
    localparam int PW    = RB + WB + 1;

    // configuration
    logic [mp2a_pkg::CFG_BITS-1:0] cfg_width_reg, cfg_width_next;
    logic [mp2a_pkg::CFG_BITS-1:0] cfg_height_reg, cfg_height_next;
    logic [KB-1:0]                 cfg_ksize_reg, cfg_ksize_next;
    logic [KB-1:0]                 cfg_stride_reg, cfg_stride_next;

    logic [WB-1:0]                 w_eff;
    logic [mp2a_pkg::CFG_BITS-1:0] h_eff;
    logic [KB-1:0]                 k_eff, k_m1, s_eff, s_m1;

    // position
    logic [CW-1:0] col_reg, col_next;
    logic [RB-1:0] row_reg, row_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [KB-1:0] ccnt_reg, ccnt_next, rcnt_reg, rcnt_next;
    logic [KB-1:0] ccnt_cur, rcnt_cur;
    logic          col_hit, row_hit, hit, row_end, plane_end, last_hit;
    logic [SW:0]   top_wide;

    // sequencer
    mp2a_pkg::state_t state_reg, state_next;
    logic [SW-1:0] i_reg, i_next, j_reg, j_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [SW-1:0] rd_i_reg, rd_j_reg;
    logic [SW-1:0] sl_reg, sl_next;
    logic [CW-1:0] c0_reg, c0_next;
    logic [RB-1:0] r0_reg, r0_next;
    logic          last_reg, last_next;

    // line store
    logic [DATA_BITS-1:0] line_mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        wr_addr, rd_addr;

    // running maximum
    logic [DATA_BITS-1:0] best_reg;
    logic [SW-1:0]        br_reg, bc_reg;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic                              out_free;
    logic [DATA_BITS-1:0]              out_value_reg;
    logic [mp2a_pkg::INDEX_BITS-1:0]   out_index_reg;
    logic [mp2a_pkg::WIN_POS_BITS-1:0] out_row_reg, out_col_reg;
    logic                              out_last_reg;
    logic [RB-1:0]                     r_abs;
    logic [CW-1:0]                     c_abs;
    logic [PW-1:0]                     index_full;

    logic pix_acc;

    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = WB'(1);
        end else if (CMPW'(cfg_width_reg) > CMPW'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(cfg_width_reg);
        end
        if (cfg_height_reg == '0) begin
            h_eff = mp2a_pkg::CFG_BITS'(1);
        end else if (cfg_height_reg > mp2a_pkg::CFG_BITS'(mp2a_pkg::MAX_HEIGHT)) begin
            h_eff = mp2a_pkg::CFG_BITS'(mp2a_pkg::MAX_HEIGHT);
        end else begin
            h_eff = cfg_height_reg;
        end
        if (cfg_ksize_reg == '0) begin
            k_eff = KB'(1);
        end else if ((KB+1)'(cfg_ksize_reg) > (KB+1)'(MAX_WINDOW)) begin
            k_eff = KB'(MAX_WINDOW);
        end else begin
            k_eff = cfg_ksize_reg;
        end
        s_eff = (cfg_stride_reg == '0) ? KB'(1) : cfg_stride_reg;
    end

    assign k_m1 = k_eff - KB'(1);
    assign s_m1 = s_eff - KB'(1);

    assign ccnt_cur  = (col_reg == '0) ? k_m1 : ccnt_reg;
    assign rcnt_cur  = (row_reg == '0) ? k_m1 : rcnt_reg;
    assign col_hit   = (ccnt_cur == '0);
    assign row_hit   = (rcnt_cur == '0);
    assign hit       = col_hit && row_hit;
    assign row_end   = ((WB+1)'(col_reg) + (WB+1)'(1)) >= (WB+1)'(w_eff);
    assign plane_end = ((RB+2)'(row_reg) + (RB+2)'(1)) >= (RB+2)'(h_eff);
    assign last_hit  = (((WB+1)'(col_reg) + (WB+1)'(s_eff)) >= (WB+1)'(w_eff)) &&
                       (((RB+2)'(row_reg) + (RB+2)'(s_eff)) >= (RB+2)'(h_eff));
    assign top_wide  = ((SW+1)'(slot_reg) >= (SW+1)'(k_m1)) ?
                       (SW+1)'(slot_reg) - (SW+1)'(k_m1) :
                       (SW+1)'(slot_reg) + (SW+1)'(MAX_WINDOW) - (SW+1)'(k_m1);

    assign s_tready = (state_reg == mp2a_pkg::S_IDLE);
    assign pix_acc  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign wr_addr = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(col_reg);
    assign rd_addr = AW'(sl_reg) * AW'(MAX_WIDTH) + AW'(c0_reg + CW'(j_reg));

    assign r_abs      = r0_reg + RB'(br_reg);
    assign c_abs      = c0_reg + CW'(bc_reg);
    assign index_full = PW'(r_abs) * PW'(w_eff) + PW'(c_abs);

    always_comb begin
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        cfg_ksize_next  = cfg_ksize_reg;
        cfg_stride_next = cfg_stride_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        slot_next       = slot_reg;
        ccnt_next       = ccnt_reg;
        rcnt_next       = rcnt_reg;
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        sl_next         = sl_reg;
        c0_next         = c0_reg;
        r0_next         = r0_reg;
        last_next       = last_reg;
        rd_valid_next   = (state_reg == mp2a_pkg::S_SCAN);
        out_valid_next  = out_valid_reg && !m_tready;

        if (cfg_wr_en) begin
            unique case (mp2a_pkg::cfg_reg_t'(cfg_addr))
                mp2a_pkg::REG_PLANE_WIDTH:   cfg_width_next  = cfg_wr_data;
                mp2a_pkg::REG_PLANE_HEIGHT:  cfg_height_next = cfg_wr_data;
                mp2a_pkg::REG_WINDOW_SIZE:   cfg_ksize_next  = cfg_wr_data[KB-1:0];
                mp2a_pkg::REG_WINDOW_STRIDE: cfg_stride_next = cfg_wr_data[KB-1:0];
            endcase
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
        end else if (pix_acc) begin
            if (row_end) begin
                col_next = '0;
                if (plane_end) begin
                    row_next  = '0;
                    slot_next = '0;
                end else begin
                    row_next  = row_reg + RB'(1);
                    slot_next = (slot_reg == SW'(MAX_WINDOW - 1)) ? '0 : slot_reg + SW'(1);
                    rcnt_next = row_hit ? s_m1 : rcnt_cur - KB'(1);
                end
            end else begin
                col_next  = col_reg + CW'(1);
                ccnt_next = col_hit ? s_m1 : ccnt_cur - KB'(1);
            end
        end

        unique case (state_reg)
            mp2a_pkg::S_IDLE: begin
                if (pix_acc && hit) begin
                    state_next = mp2a_pkg::S_SCAN;
                    i_next     = '0;
                    j_next     = '0;
                    sl_next    = top_wide[SW-1:0];
                    c0_next    = col_reg - CW'(k_m1);
                    r0_next    = row_reg - RB'(k_m1);
                    last_next  = last_hit;
                end
            end
            mp2a_pkg::S_SCAN: begin
                if (KB'(j_reg) == k_m1) begin
                    j_next = '0;
                    if (KB'(i_reg) == k_m1) begin
                        state_next = mp2a_pkg::S_DRAIN;
                    end else begin
                        i_next  = i_reg + SW'(1);
                        sl_next = (sl_reg == SW'(MAX_WINDOW - 1)) ? '0 : sl_reg + SW'(1);
                    end
                end else begin
                    j_next = j_reg + SW'(1);
                end
            end
            mp2a_pkg::S_DRAIN: begin
                state_next = mp2a_pkg::S_INDEX;
            end
            mp2a_pkg::S_INDEX: begin
                if (out_free) begin
                    state_next     = mp2a_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = mp2a_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= mp2a_pkg::CFG_BITS'(32);
            cfg_height_reg <= mp2a_pkg::CFG_BITS'(32);
            cfg_ksize_reg  <= KB'(1);
            cfg_stride_reg <= KB'(1);
            col_reg        <= '0;
            row_reg        <= '0;
            slot_reg       <= '0;
            ccnt_reg       <= '0;
            rcnt_reg       <= '0;
            state_reg      <= mp2a_pkg::S_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            cfg_ksize_reg  <= cfg_ksize_next;
            cfg_stride_reg <= cfg_stride_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            slot_reg       <= slot_next;
            ccnt_reg       <= ccnt_next;
            rcnt_reg       <= rcnt_next;
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            line_mem[wr_addr] <= s_tdata[DATA_BITS-1:0];
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        sl_reg   <= sl_next;
        c0_reg   <= c0_next;
        r0_reg   <= r0_next;
        last_reg <= last_next;
        rd_i_reg <= i_reg;
        rd_j_reg <= j_reg;
        // first sample seeds the maximum; ties keep the earlier sample
        if (rd_valid_reg && (((rd_i_reg == '0) && (rd_j_reg == '0)) ||
                             ($signed(rd_data_reg) > $signed(best_reg)))) begin
            best_reg <= rd_data_reg;
            br_reg   <= rd_i_reg;
            bc_reg   <= rd_j_reg;
        end
        if (state_reg == mp2a_pkg::S_INDEX && out_free) begin
            out_value_reg <= best_reg;
            out_index_reg <= mp2a_pkg::INDEX_BITS'(index_full);
            out_row_reg   <= mp2a_pkg::WIN_POS_BITS'(br_reg);
            out_col_reg   <= mp2a_pkg::WIN_POS_BITS'(bc_reg);
            out_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_col_reg, out_row_reg, out_index_reg, out_value_reg});
    assign m_tlast  = out_last_reg;

    `MP2A_ASSERT_IMPLY(a_scan_in_window, aclk, aresetn, state_reg == mp2a_pkg::S_SCAN, KB'(i_reg) <= k_m1 && KB'(j_reg) <= k_m1)
    `MP2A_ASSERT_IMPLY(a_read_in_scan, aclk, aresetn, rd_valid_reg, state_reg == mp2a_pkg::S_SCAN || state_reg == mp2a_pkg::S_DRAIN)
    `MP2A_ASSERT_NEXT(a_result_loaded, aclk, aresetn, state_reg == mp2a_pkg::S_INDEX && out_free, m_tvalid && state_reg == mp2a_pkg::S_IDLE)

endmodule

[test/max_pool_2d_argmax_unit_tb.sv]
module max_pool_2d_argmax_unit_tb;

    localparam int MAX_W         = 1024;
    localparam int MAX_K         = 8;
    localparam int FLUSH_CYCLES  = 80;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PIXELS = 525;

    typedef struct packed {
        logic [15:0] value;
        logic [19:0] index;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
    } window_t;

    typedef struct packed {
        logic                               is_cfg;
        logic [mp2a_pkg::CFG_ADDR_BITS-1:0] addr;
        logic [mp2a_pkg::CFG_BITS-1:0]      data;
        logic [15:0]                        px;
        logic                               typed;
        logic                               hit;
        window_t                            res;
    } stim_row_t;

    logic                               aclk        = 1'b0;
    logic                               aresetn     = 1'b0;
    logic                               cfg_wr_en   = 1'b0;
    logic [mp2a_pkg::CFG_ADDR_BITS-1:0] cfg_addr    = '0;
    logic [mp2a_pkg::CFG_BITS-1:0]      cfg_wr_data = '0;
    logic                               s_tvalid    = 1'b0;
    logic                               s_tready;
    logic [15:0]                        s_tdata     = '0;
    logic                               m_tvalid;
    logic                               m_tready    = 1'b0;
    logic [47:0]                        m_tdata;
    logic                               m_tlast;

    max_pool_2d_argmax_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [15:0]   line_mem [0:MAX_W*MAX_K-1];
    int unsigned   cur_row, cur_col;
    logic [10:0]   plane_w, plane_h;
    logic [3:0]    win_k, win_s;

    window_t       awaited_windows[$];
    stim_row_t     stim_tbl[$];
    int            mismatch_count = 0;
    int            windows_seen   = 0;
    int            pixels_sent    = 0;
    int            burst_left     = 0;

    int            hold_requests  = 0;
    int            hold_served    = 0;
    int            hold_left      = 0;
    int            rx_mode        = 0;
    int            rx_mode_left   = 0;
    logic [1:0]    rx_tick        = '0;

    function automatic int unsigned clamp_side(input int unsigned v, input int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic void add_stim_row(input stim_row_t r);
        stim_tbl.insert(stim_tbl.size(), r);
    endfunction

    function automatic void await_window(input window_t w);
        awaited_windows.insert(awaited_windows.size(), w);
    endfunction

    function automatic void model_reset();
        foreach (line_mem[i]) line_mem[i] = '0;
        cur_row = 0;
        cur_col = 0;
        plane_w = 11'd32;
        plane_h = 11'd32;
        win_k   = 4'd1;
        win_s   = 4'd1;
    endfunction

    function automatic void model_write(input mp2a_pkg::cfg_reg_t addr,
                                        input logic [mp2a_pkg::CFG_BITS-1:0] val);
        unique case (addr)
            mp2a_pkg::REG_PLANE_WIDTH:   plane_w = val;
            mp2a_pkg::REG_PLANE_HEIGHT:  plane_h = val;
            mp2a_pkg::REG_WINDOW_SIZE:   win_k   = val[3:0];
            mp2a_pkg::REG_WINDOW_STRIDE: win_s   = val[3:0];
        endcase
        cur_row = 0;
        cur_col = 0;
    endfunction

    // stores one pixel, returns 1 with the window maximum when it closes a window
    function automatic bit pool_window(input logic [15:0] px, output window_t res);
        int unsigned w, h, k, s, r, c, r0, c0, br, bc;
        logic [15:0] best, v;
        bit hit;
        w = clamp_side(plane_w, MAX_W);
        h = clamp_side(plane_h, mp2a_pkg::MAX_HEIGHT);
        k = clamp_side(win_k, MAX_K);
        s = (win_s == 0) ? 1 : win_s;
        r = (cur_row >= h) ? 0 : cur_row;
        c = (cur_col >= w) ? 0 : cur_col;
        line_mem[(r % MAX_K) * MAX_W + c] = px;
        hit = 1'b0;
        res = '0;
        if (r + 1 >= k && c + 1 >= k && k <= w && k <= h &&
            (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
            r0 = r + 1 - k;
            c0 = c + 1 - k;
            best = line_mem[(r0 % MAX_K) * MAX_W + c0];
            br = 0;
            bc = 0;
            for (int i = 0; i < k; i++) begin
                for (int j = 0; j < k; j++) begin
                    v = line_mem[((r0 + i) % MAX_K) * MAX_W + c0 + j];
                    if ($signed(v) > $signed(best)) begin
                        best = v;
                        br = i;
                        bc = j;
                    end
                end
            end
            res.value = best;
            res.index = 20'((r0 + br) * w + c0 + bc);
            res.row   = 3'(br);
            res.col   = 3'(bc);
            res.last  = (r0 == ((h - k) / s) * s) && (c0 == ((w - k) / s) * s);
            hit = 1'b1;
        end
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
            cur_row = r;
        end
        return hit;
    endfunction

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void tbl_cfg(input mp2a_pkg::cfg_reg_t a,
                                    input logic [mp2a_pkg::CFG_BITS-1:0] d);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.addr = a;
        r.data = d;
        add_stim_row(r);
    endfunction

    function automatic void tbl_pix(input logic [15:0] px);
        stim_row_t r;
        r = '0;
        r.px = px;
        add_stim_row(r);
    endfunction

    // window max sits at the window origin in every typed row
    function automatic void tbl_typed(input logic [15:0] px, input bit hit,
                                      input logic [19:0] idx, input bit last);
        stim_row_t r;
        r = '0;
        r.px = px;
        r.typed = 1'b1;
        r.hit = hit;
        r.res.value = px;
        r.res.index = idx;
        r.res.last = last;
        add_stim_row(r);
    endfunction

    task automatic offer_pixel(input logic [15:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic send_pixel(input logic [15:0] px);
        window_t res;
        if (pool_window(px, res)) await_window(res);
        offer_pixel(px);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_windows.size() != 0) @(posedge aclk);
        repeat (FLUSH_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input mp2a_pkg::cfg_reg_t addr,
                           input logic [mp2a_pkg::CFG_BITS-1:0] val);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_write(addr, val);
    endtask

    // receiver: changing ready patterns, plus long holds on request
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(10, 80);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_tick == 2'b11);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
            rx_tick <= rx_tick + 2'd1;
        end
    end

    always @(posedge aclk) begin : result_check
        window_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_windows.size() == 0) begin
                $error("unexpected window word %h last %b", m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = awaited_windows.pop_front();
                windows_seen++;
                if (m_tdata[15:0] !== want.value) begin
                    $error("max_value expected %h got %h", want.value, m_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_tdata[35:16] !== want.index) begin
                    $error("max_index expected %0d got %0d", want.index, m_tdata[35:16]);
                    mismatch_count++;
                end
                if (m_tdata[38:36] !== want.row) begin
                    $error("win_row expected %0d got %0d", want.row, m_tdata[38:36]);
                    mismatch_count++;
                end
                if (m_tdata[41:39] !== want.col) begin
                    $error("win_col expected %0d got %0d", want.col, m_tdata[41:39]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_plane expected %b got %b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        window_t     res;
        stim_row_t   row;
        int unsigned w, h, k, s, ke, we, he, n;
        int          phase;
        int          random_sent;

        model_reset();

        // reset values: 1x1 window, every pixel is its own maximum
        tbl_typed(16'h8000, 1'b1, 20'd0, 1'b0);
        tbl_typed(16'h7FFF, 1'b1, 20'd1, 1'b0);
        tbl_typed(16'h0001, 1'b1, 20'd2, 1'b0);
        // 2x2 plane, one 2x2 window: all equal, first element wins
        tbl_cfg(mp2a_pkg::REG_PLANE_WIDTH, 11'd2);
        tbl_cfg(mp2a_pkg::REG_PLANE_HEIGHT, 11'd2);
        tbl_cfg(mp2a_pkg::REG_WINDOW_SIZE, 11'd2);
        tbl_typed(16'h0100, 1'b0, 20'd0, 1'b0);
        tbl_typed(16'h0100, 1'b0, 20'd0, 1'b0);
        tbl_typed(16'h0100, 1'b0, 20'd0, 1'b0);
        tbl_typed(16'h0100, 1'b1, 20'd0, 1'b1);
        tbl_pix(16'h8000);
        tbl_pix(16'h8001);
        tbl_pix(16'hFFFF);
        tbl_pix(16'h7FFF);
        // window wider than the plane
        tbl_cfg(mp2a_pkg::REG_WINDOW_SIZE, 11'd3);
        tbl_typed(16'h5555, 1'b0, 20'd0, 1'b0);
        tbl_typed(16'h5555, 1'b0, 20'd0, 1'b0);
        tbl_typed(16'h5555, 1'b0, 20'd0, 1'b0);
        // zeros in every register act as a 1x1 plane and window
        tbl_cfg(mp2a_pkg::REG_PLANE_WIDTH, 11'd0);
        tbl_cfg(mp2a_pkg::REG_PLANE_HEIGHT, 11'd0);
        tbl_cfg(mp2a_pkg::REG_WINDOW_SIZE, 11'd0);
        tbl_cfg(mp2a_pkg::REG_WINDOW_STRIDE, 11'd0);
        tbl_typed(16'hAAAA, 1'b1, 20'd0, 1'b1);
        tbl_typed(16'h0000, 1'b1, 20'd0, 1'b1);
        // 3x3 plane, 2x2 window, stride 2: last row and column uncovered
        tbl_cfg(mp2a_pkg::REG_PLANE_WIDTH, 11'd3);
        tbl_cfg(mp2a_pkg::REG_PLANE_HEIGHT, 11'd3);
        tbl_cfg(mp2a_pkg::REG_WINDOW_SIZE, 11'd2);
        tbl_cfg(mp2a_pkg::REG_WINDOW_STRIDE, 11'd2);
        tbl_pix(16'hFFFF);
        tbl_pix(16'h0000);
        tbl_pix(16'h8000);
        tbl_pix(16'h0001);
        tbl_pix(16'hFFFE);
        tbl_pix(16'h7FFF);
        tbl_pix(16'h7FFF);
        tbl_pix(16'h1234);
        tbl_pix(16'h7FFF);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_tbl[i]) begin
            row = stim_tbl[i];
            if (row.is_cfg) begin
                set_reg(mp2a_pkg::cfg_reg_t'(row.addr), row.data);
            end else if (row.typed) begin
                void'(pool_window(row.px, res));
                if (row.hit) await_window(row.res);
                offer_pixel(row.px);
            end else begin
                send_pixel(row.px);
            end
        end

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS || phase < 6) begin
            case (phase)
                0: begin w = 2047; h = 2047; k = 1; s = 1;  n = 40;  end
                1: begin w = 1;    h = 1024; k = 1; s = 2;  n = 40;  end
                2: begin w = 8;    h = 8;    k = 8; s = 8;  n = 128; end
                3: begin w = 9;    h = 9;    k = 8; s = 1;  n = 100; end
                default: begin
                    ke = ($urandom_range(0, 5) == 0) ? $urandom_range(5, MAX_K)
                                                     : $urandom_range(1, 4);
                    k = ke;
                    if (ke == MAX_K && $urandom_range(0, 1) == 1) k = $urandom_range(MAX_K + 1, 15);
                    if (ke == 1 && $urandom_range(0, 3) == 0) k = 0;
                    w = $urandom_range(ke > 1 ? ke - 1 : 1, ke + 4);
                    h = $urandom_range(ke > 1 ? ke - 1 : 1, ke + 4);
                    if ($urandom_range(0, 9) == 0) w = 0;
                    case ($urandom_range(0, 7))
                        0: s = 0;
                        1: s = $urandom_range(4, 15);
                        default: s = $urandom_range(1, 3);
                    endcase
                    we = clamp_side(w, MAX_W);
                    he = clamp_side(h, mp2a_pkg::MAX_HEIGHT);
                    n = $urandom_range(1, 2) * we * he + $urandom_range(0, we * he - 1);
                    if (random_sent + int'(n) > RANDOM_PIXELS) begin
                        n = (random_sent + 4 < RANDOM_PIXELS) ? RANDOM_PIXELS - random_sent : 4;
                    end
                end
            endcase
            set_reg(mp2a_pkg::REG_PLANE_WIDTH, mp2a_pkg::CFG_BITS'(w));
            set_reg(mp2a_pkg::REG_PLANE_HEIGHT, mp2a_pkg::CFG_BITS'(h));
            set_reg(mp2a_pkg::REG_WINDOW_SIZE, {7'($urandom), 4'(k)});
            set_reg(mp2a_pkg::REG_WINDOW_STRIDE, {7'($urandom), 4'(s)});
            if (phase == 0) hold_requests <= hold_requests + 1;
            for (int i = 0; i < n; i++) begin
                if (phase == 5 && i == n / 2) settle();
                send_pixel(pick_pixel());
                random_sent++;
            end
            phase++;
        end

        settle();
        $display("%0d pixels over %0d plane settings, %0d window results compared",
                 pixels_sent, phase, windows_seen);
        $display("window sides 1 to 8, strides 0 to 15, saturated plane sides, long output stall");
        if (mismatch_count == 0 && awaited_windows.size() == 0) begin
            $display("max_pool_2d_argmax_unit_tb OK");
        end else begin
            $display("max_pool_2d_argmax_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout with %0d windows outstanding", awaited_windows.size());
        $display("max_pool_2d_argmax_unit_tb NOT OK");
        $finish;
    end

endmodule
